### rtl/rrsp_pkg.sv
// Shared types and constants for the round-robin server picker.
// Field widths, request and status codes, queue entry and back-end state types.
// No dependencies.
package rrsp_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int REQ_W      = 2;
    localparam int SLOT_IN_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int NUM_W      = 5;
    localparam int HOLD_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int S_HDR_W    = 9;
    localparam int M_TDATA_W  = 8;

    // Request codes carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_PICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DISABLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ENABLE  = 2'd2;

    // Result status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SERVERS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_HOLDOFF = 1'b1;

    // Request class decided by the front end
    typedef enum logic [1:0] {
        KIND_PICK,
        KIND_DISABLE,
        KIND_ENABLE,
        KIND_REJECT
    } kind_t;

    // One classified request as held in the queue
    typedef struct packed {
        kind_t                kind;
        logic [SLOT_IN_W-1:0] slot_index;
        logic                 use_start;
        logic [SLOT_IN_W-1:0] start_index;
    } req_entry_t;

    localparam int ENTRY_W = $bits(req_entry_t);

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_RESP
    } back_state_t;

endpackage

### rtl/rrsp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rrsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rrsp_fifo.sv
// Short request queue between the front and back ends.
// No dependencies.
module rrsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

endmodule

### rtl/rrsp_front.sv
// Front end: takes requests off the input stream and classifies them.
// Depends on rrsp_pkg.
module rrsp_front #(
    parameter int MAX_SLOTS = 16,
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1)
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrsp_pkg::REQ_W-1:0]     req_type,
    input  logic [rrsp_pkg::SLOT_IN_W-1:0] slot_index,
    input  logic                           use_start,
    input  logic [rrsp_pkg::SLOT_IN_W-1:0] start_index,
    input  logic [CNT_W-1:0]               used_n,
    input  logic                           q_full,
    output logic                           q_push,
    output rrsp_pkg::req_entry_t           q_entry
);

    localparam int CMP_W = (CNT_W > rrsp_pkg::SLOT_IN_W) ? CNT_W : rrsp_pkg::SLOT_IN_W;

    logic slot_bad;

    assign slot_bad = (CMP_W'(slot_index) >= CMP_W'(used_n));

    // Classify the request; bad slots and unknown codes are rejected here
    always_comb begin
        q_entry.slot_index  = slot_index;
        q_entry.use_start   = use_start;
        q_entry.start_index = start_index;
        case (req_type)
            rrsp_pkg::REQ_PICK:    q_entry.kind = rrsp_pkg::KIND_PICK;
            rrsp_pkg::REQ_DISABLE: q_entry.kind = slot_bad ? rrsp_pkg::KIND_REJECT
                                                           : rrsp_pkg::KIND_DISABLE;
            rrsp_pkg::REQ_ENABLE:  q_entry.kind = slot_bad ? rrsp_pkg::KIND_REJECT
                                                           : rrsp_pkg::KIND_ENABLE;
            default:               q_entry.kind = rrsp_pkg::KIND_REJECT;
        endcase
    end

    // Accept while the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

### rtl/rrsp_back.sv
// Back end: executes queued requests, scans slots one per cycle, holds the result.
// Depends on rrsp_pkg and rrsp_ram (failure-time store).
module rrsp_back #(
    parameter int MAX_SLOTS  = 16,
    parameter int TIME_WIDTH = 32,
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1),
    localparam int SLOT_W    = $clog2(MAX_SLOTS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  rrsp_pkg::req_entry_t          q_entry,
    input  logic [TIME_WIDTH-1:0]         q_now,
    output logic                          q_pop,
    input  logic [CNT_W-1:0]              used_n,
    input  logic [rrsp_pkg::HOLD_W-1:0]   holdoff,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rrsp_pkg::STATUS_W-1:0] m_status,
    output logic [rrsp_pkg::SLOT_IN_W-1:0] m_chosen
);

    localparam int CMP_A = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int CMP_W = (CMP_A > rrsp_pkg::SLOT_IN_W) ? CMP_A : rrsp_pkg::SLOT_IN_W;

    rrsp_pkg::back_state_t state_reg, state_next;

    logic [MAX_SLOTS-1:0]           svc_reg, svc_next;
    logic [SLOT_W-1:0]              ptr_reg, ptr_next;
    logic [SLOT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [TIME_WIDTH-1:0]          now_reg, now_next;
    logic [rrsp_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [rrsp_pkg::SLOT_IN_W-1:0] res_chosen_reg, res_chosen_next;
    logic                           m_valid_reg, m_valid_next;
    logic [rrsp_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [rrsp_pkg::SLOT_IN_W-1:0] m_chosen_reg, m_chosen_next;

    logic [CMP_W-1:0]      start_wide;
    logic                  start_bad;
    logic [SLOT_W-1:0]     start_idx;
    logic [SLOT_W:0]       idx_inc;
    logic [SLOT_W-1:0]     idx_wrap;
    logic [SLOT_W-1:0]     head_slot;
    logic [TIME_WIDTH:0]   expire_sum;
    logic                  expired;
    logic                  hit;
    logic                  last_visit;
    logic                  out_free;
    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    logic [TIME_WIDTH-1:0] ram_rd_data;

    // Failure times, written on disable, read during the scan
    rrsp_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (MAX_SLOTS)
    ) u_fail_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (head_slot),
        .wr_data (q_now),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Starting slot and its range check
    assign start_wide = q_entry.use_start ? CMP_W'(q_entry.start_index) : CMP_W'(ptr_reg);
    assign start_bad  = (start_wide >= CMP_W'(used_n));
    assign start_idx  = SLOT_W'(start_wide);
    assign head_slot  = SLOT_W'(q_entry.slot_index);

    // Wrapping successor of the slot under test
    assign idx_inc  = {1'b0, idx_reg} + (SLOT_W + 1)'(1);
    assign idx_wrap = (idx_inc >= (SLOT_W + 1)'(used_n)) ? '0 : idx_inc[SLOT_W-1:0];

    // Holdoff test with one extra bit so the sum cannot wrap
    assign expire_sum = {1'b0, ram_rd_data} + (TIME_WIDTH + 1)'(holdoff);
    assign expired    = (expire_sum < {1'b0, now_reg});
    assign hit        = svc_reg[idx_reg] || expired;
    assign last_visit = ((count_reg + CNT_W'(1)) == used_n);
    assign out_free   = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrsp_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (q_entry.kind == rrsp_pkg::KIND_PICK && used_n != '0 && !start_bad) begin
                        state_next = rrsp_pkg::BK_CHECK;
                    end else begin
                        state_next = rrsp_pkg::BK_RESP;
                    end
                end
            end
            rrsp_pkg::BK_CHECK: begin
                if (hit || last_visit) begin
                    state_next = rrsp_pkg::BK_RESP;
                end
            end
            rrsp_pkg::BK_RESP: begin
                if (out_free) begin
                    state_next = rrsp_pkg::BK_IDLE;
                end
            end
            default: state_next = rrsp_pkg::BK_IDLE;
        endcase
    end

    // Datapath controls and register updates
    always_comb begin
        q_pop           = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_addr     = idx_wrap;
        svc_next        = svc_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        res_status_next = res_status_reg;
        res_chosen_next = res_chosen_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_chosen_next   = m_chosen_reg;
        unique case (state_reg)
            rrsp_pkg::BK_IDLE: begin
                ram_rd_addr = start_idx;
                if (q_valid) begin
                    q_pop           = 1'b1;
                    now_next        = q_now;
                    idx_next        = start_idx;
                    count_next      = '0;
                    res_chosen_next = '0;
                    res_status_next = rrsp_pkg::STATUS_OK;
                    case (q_entry.kind)
                        rrsp_pkg::KIND_PICK: begin
                            if (used_n == '0) begin
                                res_status_next = rrsp_pkg::STATUS_NONE;
                            end else if (start_bad) begin
                                res_status_next = rrsp_pkg::STATUS_RANGE;
                            end
                        end
                        rrsp_pkg::KIND_DISABLE: begin
                            ram_wr_en           = 1'b1;
                            svc_next[head_slot] = 1'b0;
                        end
                        rrsp_pkg::KIND_ENABLE: begin
                            svc_next[head_slot] = 1'b1;
                        end
                        default: begin
                            res_status_next = rrsp_pkg::STATUS_RANGE;
                        end
                    endcase
                end
            end
            rrsp_pkg::BK_CHECK: begin
                if (hit) begin
                    svc_next[idx_reg] = 1'b1;
                    res_status_next   = rrsp_pkg::STATUS_OK;
                    res_chosen_next   = rrsp_pkg::SLOT_IN_W'(idx_reg);
                    ptr_next          = idx_wrap;
                end else if (last_visit) begin
                    res_status_next = rrsp_pkg::STATUS_NONE;
                end else begin
                    idx_next   = idx_wrap;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            rrsp_pkg::BK_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_chosen_next = res_chosen_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrsp_pkg::BK_IDLE;
            svc_reg     <= '1;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            svc_reg     <= svc_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_chosen_reg <= res_chosen_next;
        m_status_reg   <= m_status_next;
        m_chosen_reg   <= m_chosen_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_chosen = m_chosen_reg;

endmodule

### rtl/round_robin_server_pick_with_holdoff.sv
// Sequence: the back end takes each queued request in its idle state; a pick then scans, in its
// check state, from one slot up to every slot in use; each request ends in the response state,
// which registers the result. It finishes one request before taking the next; the scan reads one
// failure time per cycle from its RAM port. A 2-entry queue decouples input from execution.
// Reset: all slots in service, next pointer zero, num_servers 1, retry_holdoff 10,
// queue and output empty. No clearing pass: failure times are written before they are read.
module round_robin_server_pick_with_holdoff #(
    parameter int MAX_SLOTS  = 16,
    parameter int TIME_WIDTH = 32,
    localparam int S_TDATA_W = ((rrsp_pkg::S_HDR_W + TIME_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: slot_index[3:0], use_start[4], start_index[8:5], now_time[TIME_WIDTH+8:9]
    input  logic [S_TDATA_W-1:0]             s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [rrsp_pkg::REQ_W-1:0]       s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: chosen_slot[3:0], zeros above
    output logic [rrsp_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: status[1:0]
    output logic [rrsp_pkg::STATUS_W-1:0]    m_tuser,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [rrsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rrsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (CNT_W > rrsp_pkg::NUM_W) ? CNT_W : rrsp_pkg::NUM_W;
    localparam int Q_DEPTH = 2;
    localparam int Q_W     = rrsp_pkg::ENTRY_W + TIME_WIDTH;

    logic [rrsp_pkg::NUM_W-1:0]  num_servers_reg;
    logic [rrsp_pkg::HOLD_W-1:0] holdoff_reg;
    logic [CMP_W-1:0]            num_wide;
    logic [CNT_W-1:0]            used_n;

    rrsp_pkg::req_entry_t        front_entry;
    rrsp_pkg::req_entry_t        head_entry;
    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    logic [Q_W-1:0]              q_head;
    logic [TIME_WIDTH-1:0]       head_now;
    logic [rrsp_pkg::SLOT_IN_W-1:0] m_chosen;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_servers_reg <= rrsp_pkg::NUM_W'(1);
            holdoff_reg     <= rrsp_pkg::HOLD_W'(10);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rrsp_pkg::REG_NUM_SERVERS:   num_servers_reg <= cfg_wdata[rrsp_pkg::NUM_W-1:0];
                rrsp_pkg::REG_RETRY_HOLDOFF: holdoff_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Clamp the slot count to the storage depth
    assign num_wide = CMP_W'(num_servers_reg);
    assign used_n   = (num_wide > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(num_wide);

    rrsp_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .slot_index  (s_tdata[3:0]),
        .use_start   (s_tdata[4]),
        .start_index (s_tdata[8:5]),
        .used_n      (used_n),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (front_entry)
    );

    rrsp_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({s_tdata[rrsp_pkg::S_HDR_W +: TIME_WIDTH], front_entry}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (q_head)
    );

    assign head_entry = rrsp_pkg::req_entry_t'(q_head[rrsp_pkg::ENTRY_W-1:0]);
    assign head_now   = q_head[Q_W-1:rrsp_pkg::ENTRY_W];

    rrsp_back #(
        .MAX_SLOTS  (MAX_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_now    (head_now),
        .q_pop    (q_pop),
        .used_n   (used_n),
        .holdoff  (holdoff_reg),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_status (m_tuser),
        .m_chosen (m_chosen)
    );

    assign m_tdata = rrsp_pkg::M_TDATA_W'(m_chosen);

endmodule

### rtl/rrsp_checker.sv
// Port-level checks on the round-robin server picker, bound to its top level.
// Depends on rrsp_pkg and round_robin_server_pick_with_holdoff.
module rrsp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rrsp_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [rrsp_pkg::STATUS_W-1:0]   m_tuser
);

    // Reset empties the output stage
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only a successful pick names a slot
    a_chosen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != rrsp_pkg::STATUS_OK |-> m_tdata == '0)
        else $error("slot reported on a failed request");

    // Status carries one of the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == rrsp_pkg::STATUS_OK || m_tuser == rrsp_pkg::STATUS_NONE
                      || m_tuser == rrsp_pkg::STATUS_RANGE))
        else $error("undefined status code");

endmodule

bind round_robin_server_pick_with_holdoff rrsp_checker u_rrsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/tb_top.sv
// Self-checking testbench for the round-robin server picker with failover holdoff.
// Holds a scoreboard class that predicts each result and a top module that drives the
// request stream and the register port. Depends on rrsp_pkg and the picker RTL only.
`timescale 1ns / 100ps

// Expected outcome of one request
typedef struct packed {
    logic [rrsp_pkg::STATUS_W-1:0]  status;
    logic [rrsp_pkg::SLOT_IN_W-1:0] slot;
} pick_result_t;

class pick_scoreboard;
    localparam int SLOT_COUNT = 16;
    localparam int TIME_BITS  = 32;

    // Mirror of the slot table, rotating pointer and registers
    bit                           in_service [SLOT_COUNT];
    logic [TIME_BITS-1:0]         fail_time [SLOT_COUNT];
    int                           next_slot;
    logic [rrsp_pkg::NUM_W-1:0]   num_servers;
    logic [rrsp_pkg::HOLD_W-1:0]  holdoff;
    pick_result_t                 expected_q [$];
    int unsigned                  fail_count;

    function new();
        for (int k = 0; k < SLOT_COUNT; k++) begin
            in_service[k] = 1'b1;
            fail_time[k]  = '0;
        end
        next_slot   = 0;
        num_servers = rrsp_pkg::NUM_W'(1);
        holdoff     = rrsp_pkg::HOLD_W'(10);
        fail_count  = 0;
    endfunction

    function void write_reg(logic [rrsp_pkg::CFG_IDX_W-1:0] idx,
                            logic [rrsp_pkg::CFG_DATA_W-1:0] data);
        if (idx == rrsp_pkg::REG_NUM_SERVERS)
            num_servers = data[rrsp_pkg::NUM_W-1:0];
        else
            holdoff = data[rrsp_pkg::HOLD_W-1:0];
    endfunction

    // Work out the outcome of one accepted request and update the slot table
    function void note_request(logic [rrsp_pkg::REQ_W-1:0] req, logic [3:0] slot,
                               logic use_start, logic [3:0] start,
                               logic [TIME_BITS-1:0] now);
        pick_result_t   r;
        int             used;
        int             idx;
        logic [TIME_BITS:0] expiry;
        used     = (num_servers > SLOT_COUNT) ? SLOT_COUNT : int'(num_servers);
        r.status = rrsp_pkg::STATUS_OK;
        r.slot   = '0;
        case (req) inside
            rrsp_pkg::REQ_PICK: begin
                idx      = use_start ? int'(start) : next_slot;
                r.status = rrsp_pkg::STATUS_NONE;
                for (int c = 0; c < used; c++) begin
                    if (idx >= used) begin
                        r.status = rrsp_pkg::STATUS_RANGE;
                        break;
                    end
                    // re-enable a failed slot once its holdoff has run out (no wrap)
                    expiry = {1'b0, fail_time[idx]} + {{(TIME_BITS-15){1'b0}}, holdoff};
                    if (!in_service[idx] && expiry < {1'b0, now}) begin
                        in_service[idx] = 1'b1;
                        fail_time[idx]  = '0;
                    end
                    if (in_service[idx]) begin
                        r.status  = rrsp_pkg::STATUS_OK;
                        r.slot    = 4'(idx);
                        next_slot = (idx + 1 >= used) ? 0 : idx + 1;
                        break;
                    end
                    idx = (idx + 1 >= used) ? 0 : idx + 1;
                end
            end
            rrsp_pkg::REQ_DISABLE, rrsp_pkg::REQ_ENABLE: begin
                if (int'(slot) >= used) begin
                    r.status = rrsp_pkg::STATUS_RANGE;
                end else if (req == rrsp_pkg::REQ_DISABLE) begin
                    in_service[slot] = 1'b0;
                    fail_time[slot]  = now;
                end else begin
                    in_service[slot] = 1'b1;
                    fail_time[slot]  = '0;
                end
            end
            default: r.status = rrsp_pkg::STATUS_RANGE;
        endcase
        expected_q.push_back(r);
    endfunction

    task report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Compare one result transaction against the oldest expectation
    task check_result(logic [rrsp_pkg::M_TDATA_W-1:0] tdata,
                      logic [rrsp_pkg::STATUS_W-1:0] tuser);
        pick_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d slot %0d", tuser, tdata));
            return;
        end
        want = expected_q.pop_front();
        if (tuser !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", tuser, want.status));
        if (tdata !== {{(rrsp_pkg::M_TDATA_W-4){1'b0}}, want.slot})
            report_mismatch($sformatf("chosen slot %0d, wanted %0d", tdata, want.slot));
    endtask
endclass

module tb_top;

    localparam int TIME_W     = 32;
    localparam int S_TDATA_W  = ((rrsp_pkg::S_HDR_W + TIME_W + 7) / 8) * 8;
    localparam int LIMIT      = 400000;
    localparam int LONG_STALL = 150;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 70;
    localparam logic [rrsp_pkg::REQ_W-1:0] REQ_BAD = 2'd3;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [S_TDATA_W-1:0]              s_tdata;
    logic [rrsp_pkg::REQ_W-1:0]        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [rrsp_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [rrsp_pkg::STATUS_W-1:0]     m_tuser;
    logic                              cfg_wr_en;
    logic [rrsp_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [rrsp_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    pick_scoreboard sb = new();

    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          stall_requests  = 0;
    int          stall_served    = 0;
    int          hold_left       = 0;
    int unsigned cycle_count     = 0;
    logic [TIME_W-1:0] clock_now = '0;

    // Register settings per random phase; the third carries junk above the count bits
    logic [rrsp_pkg::CFG_DATA_W-1:0] phase_num  [PHASES] =
        '{16'd16, 16'd5, 16'hFFE3, 16'd31, 16'd1, 16'd8, 16'd20, 16'd2};
    logic [rrsp_pkg::CFG_DATA_W-1:0] phase_hold [PHASES] =
        '{16'hFFFF, 16'd0, 16'd25, 16'd3, 16'd10, 16'd1000, 16'd7, 16'd0};

    round_robin_server_pick_with_holdoff uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check each transaction, then choose the next ready value
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold_left    = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(int mode);
        case (mode)
            0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin sender_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin sender_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    // Write both registers on consecutive edges
    task automatic set_config(logic [rrsp_pkg::CFG_DATA_W-1:0] num_data,
                              logic [rrsp_pkg::CFG_DATA_W-1:0] hold_data);
        cfg_wr_en <= 1'b1;
        cfg_index <= rrsp_pkg::REG_NUM_SERVERS;
        cfg_wdata <= num_data;
        @(posedge aclk);
        sb.write_reg(rrsp_pkg::REG_NUM_SERVERS, num_data);
        cfg_index <= rrsp_pkg::REG_RETRY_HOLDOFF;
        cfg_wdata <= hold_data;
        @(posedge aclk);
        sb.write_reg(rrsp_pkg::REG_RETRY_HOLDOFF, hold_data);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one request, with an optional idle gap first, and hold until accepted
    task automatic send_req(logic [rrsp_pkg::REQ_W-1:0] req, logic [3:0] slot,
                            logic use_start, logic [3:0] start, logic [TIME_W-1:0] now);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({now, start, use_start, slot});
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, slot, use_start, start, now);
    endtask

    // Mostly in-range slots and a slowly advancing clock, with some wild values
    task automatic send_random();
        int                          used;
        int                          roll;
        logic [rrsp_pkg::REQ_W-1:0]  req;
        logic [3:0]                  slot;
        logic [3:0]                  start;
        logic                        use_start;
        logic [TIME_W-1:0]           now;
        used = (sb.num_servers > 16) ? 16 : int'(sb.num_servers);
        roll = $urandom_range(99);
        if (roll < 50)      req = rrsp_pkg::REQ_PICK;
        else if (roll < 75) req = rrsp_pkg::REQ_DISABLE;
        else if (roll < 94) req = rrsp_pkg::REQ_ENABLE;
        else                req = REQ_BAD;
        slot  = (used > 0 && $urandom_range(99) < 85) ? 4'($urandom_range(used - 1))
                                                      : 4'($urandom_range(15));
        start = (used > 0 && $urandom_range(99) < 85) ? 4'($urandom_range(used - 1))
                                                      : 4'($urandom_range(15));
        use_start = ($urandom_range(99) < 25);
        clock_now = clock_now + $urandom_range(int'(sb.holdoff >> 2) + 3);
        now = ($urandom_range(11) == 0) ? $urandom() : clock_now;
        send_req(req, slot, use_start, start, now);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= rrsp_pkg::REQ_PICK;
        cfg_wr_en <= 1'b0;
        cfg_index <= rrsp_pkg::REG_NUM_SERVERS;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one slot, unknown request, index and start out of range
        send_req(rrsp_pkg::REQ_PICK,    4'd0,  1'b0, 4'd0,  32'd0);
        send_req(REQ_BAD,               4'd15, 1'b1, 4'd15, 32'hFFFF_FFFF);
        send_req(rrsp_pkg::REQ_DISABLE, 4'd1,  1'b0, 4'd0,  32'd3);
        send_req(rrsp_pkg::REQ_PICK,    4'd0,  1'b1, 4'd15, 32'd3);
        wait_idle();

        // All sixteen slots, widest holdoff: no wrap in the expiry sum, exact boundary
        set_config(16'd16, 16'hFFFF);
        send_req(rrsp_pkg::REQ_DISABLE, 4'd0,  1'b0, 4'd0, 32'hFFFF_FFFF);
        send_req(rrsp_pkg::REQ_DISABLE, 4'd15, 1'b0, 4'd0, 32'd5);
        send_req(rrsp_pkg::REQ_ENABLE,  4'd15, 1'b0, 4'd0, 32'd0);
        send_req(rrsp_pkg::REQ_PICK,    4'd0,  1'b1, 4'd0, 32'hFFFF_FFFF);
        send_req(rrsp_pkg::REQ_DISABLE, 4'd2,  1'b0, 4'd0, 32'd100);
        send_req(rrsp_pkg::REQ_PICK,    4'd0,  1'b1, 4'd2, 32'd100 + 32'hFFFF);
        send_req(rrsp_pkg::REQ_PICK,    4'd0,  1'b1, 4'd2, 32'd100 + 32'h10000);
        wait_idle();

        // Two slots, zero holdoff: nothing in service, stale pointer, wrap
        set_config(16'd2, 16'd0);
        send_req(rrsp_pkg::REQ_DISABLE, 4'd0, 1'b0, 4'd0, 32'd7);
        send_req(rrsp_pkg::REQ_DISABLE, 4'd1, 1'b0, 4'd0, 32'd7);
        send_req(rrsp_pkg::REQ_PICK,    4'd0, 1'b1, 4'd0, 32'd7);
        send_req(rrsp_pkg::REQ_PICK,    4'd0, 1'b0, 4'd0, 32'd8);
        send_req(rrsp_pkg::REQ_PICK,    4'd0, 1'b1, 4'd1, 32'd8);
        send_req(rrsp_pkg::REQ_PICK,    4'd0, 1'b0, 4'd0, 32'd7);
        wait_idle();

        // No slots in use
        set_config(16'd0, 16'd0);
        send_req(rrsp_pkg::REQ_PICK,   4'd0, 1'b0, 4'd0, 32'd9);
        send_req(rrsp_pkg::REQ_ENABLE, 4'd0, 1'b0, 4'd0, 32'd9);
        wait_idle();

        // Random phases across register settings and idle patterns
        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_num[p], phase_hold[p]);
            set_idle(p % 4);
            // long receiver hold-off so the input side backs up
            if (p == 0)
                stall_requests++;
            repeat (PHASE_LEN) send_random();
            wait_idle();
        end

        if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
